@@ hw/rtl/psm_pkg.sv @@
// Shared types, constants and the control store for the packed slot map.
`timescale 1ns / 1ps
package psm_pkg;

	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int HANDLE_W   = 8;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int SLOT_W     = $clog2(CAPACITY + 1);
	localparam int PC_W       = 4;
	localparam int ACT_W      = 4;
	localparam int COND_W     = 2;

	localparam logic [SLOT_W-1:0] DEAD_SLOT = SLOT_W'(CAPACITY);

	// Request operations
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;
	localparam logic [1:0] OP_REMOVE = 2'd3;

	// Result status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// Datapath actions
	localparam logic [ACT_W-1:0] A_NOP     = 4'd0;
	localparam logic [ACT_W-1:0] A_RD_FREE = 4'd1;
	localparam logic [ACT_W-1:0] A_ADD     = 4'd2;
	localparam logic [ACT_W-1:0] A_RD_H2S  = 4'd3;
	localparam logic [ACT_W-1:0] A_RD_DATA = 4'd4;
	localparam logic [ACT_W-1:0] A_OUT     = 4'd5;
	localparam logic [ACT_W-1:0] A_SLOT    = 4'd6;
	localparam logic [ACT_W-1:0] A_WR      = 4'd7;
	localparam logic [ACT_W-1:0] A_RM_RD   = 4'd8;
	localparam logic [ACT_W-1:0] A_RM_MOVE = 4'd9;
	localparam logic [ACT_W-1:0] A_RM_FREE = 4'd10;
	localparam logic [ACT_W-1:0] A_BAD     = 4'd11;
	localparam logic [ACT_W-1:0] A_FULL    = 4'd12;

	// Jump conditions
	localparam logic [COND_W-1:0] C_NONE  = 2'd0;
	localparam logic [COND_W-1:0] C_FULL  = 2'd1;
	localparam logic [COND_W-1:0] C_UNISS = 2'd2;
	localparam logic [COND_W-1:0] C_DEAD  = 2'd3;

	// Program addresses
	localparam logic [PC_W-1:0] P_IDLE = 4'd0;
	localparam logic [PC_W-1:0] P_ADD0 = 4'd1;
	localparam logic [PC_W-1:0] P_ADD1 = 4'd2;
	localparam logic [PC_W-1:0] P_RD0  = 4'd3;
	localparam logic [PC_W-1:0] P_RD1  = 4'd4;
	localparam logic [PC_W-1:0] P_RD2  = 4'd5;
	localparam logic [PC_W-1:0] P_WR0  = 4'd6;
	localparam logic [PC_W-1:0] P_WR1  = 4'd7;
	localparam logic [PC_W-1:0] P_WR2  = 4'd8;
	localparam logic [PC_W-1:0] P_RM0  = 4'd9;
	localparam logic [PC_W-1:0] P_RM1  = 4'd10;
	localparam logic [PC_W-1:0] P_RM2  = 4'd11;
	localparam logic [PC_W-1:0] P_RM3  = 4'd12;
	localparam logic [PC_W-1:0] P_BAD  = 4'd13;
	localparam logic [PC_W-1:0] P_FULL = 4'd14;

	typedef struct packed {
		logic [1:0]          op;
		logic [HANDLE_W-1:0] handle;
		logic [31:0]         value;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle_out;
		logic [31:0]         value_out;
		logic [8:0]          live_count;
	} rsp_t;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic              fin;
	} ucw_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             fin;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic uniss;
		logic dead;
	} flags_t;

	function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = '{act: A_NOP, cond: C_NONE, target: P_IDLE, fin: 1'b0};
		case (pc)
			P_ADD0: w = '{act: A_RD_FREE, cond: C_FULL,  target: P_FULL, fin: 1'b0};
			P_ADD1: w = '{act: A_ADD,     cond: C_NONE,  target: P_IDLE, fin: 1'b1};
			P_RD0:  w = '{act: A_RD_H2S,  cond: C_UNISS, target: P_BAD,  fin: 1'b0};
			P_RD1:  w = '{act: A_RD_DATA, cond: C_DEAD,  target: P_BAD,  fin: 1'b0};
			P_RD2:  w = '{act: A_OUT,     cond: C_NONE,  target: P_IDLE, fin: 1'b1};
			P_WR0:  w = '{act: A_RD_H2S,  cond: C_UNISS, target: P_BAD,  fin: 1'b0};
			P_WR1:  w = '{act: A_SLOT,    cond: C_DEAD,  target: P_BAD,  fin: 1'b0};
			P_WR2:  w = '{act: A_WR,      cond: C_NONE,  target: P_IDLE, fin: 1'b1};
			P_RM0:  w = '{act: A_RD_H2S,  cond: C_UNISS, target: P_BAD,  fin: 1'b0};
			P_RM1:  w = '{act: A_RM_RD,   cond: C_DEAD,  target: P_BAD,  fin: 1'b0};
			P_RM2:  w = '{act: A_RM_MOVE, cond: C_NONE,  target: P_IDLE, fin: 1'b0};
			P_RM3:  w = '{act: A_RM_FREE, cond: C_NONE,  target: P_IDLE, fin: 1'b1};
			P_BAD:  w = '{act: A_BAD,     cond: C_NONE,  target: P_IDLE, fin: 1'b1};
			P_FULL: w = '{act: A_FULL,    cond: C_NONE,  target: P_IDLE, fin: 1'b1};
			default: w = '{act: A_NOP, cond: C_NONE, target: P_IDLE, fin: 1'b0};
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/psm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module psm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/psm_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
module psm_seq
	import psm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] op,
	input  flags_t     flags,
	output logic       busy,
	output ctl_t       ctl
);

	logic [PC_W-1:0] pc_q;
	ucw_t            ucw;
	logic            take;
	logic [PC_W-1:0] entry;

	assign ucw  = ucode_rom(pc_q);
	assign busy = (pc_q != P_IDLE);
	assign ctl  = '{act: ucw.act, fin: ucw.fin};

	always_comb begin
		case (ucw.cond)
			C_FULL:  take = flags.full;
			C_UNISS: take = flags.uniss;
			C_DEAD:  take = flags.dead;
			default: take = 1'b0;
		endcase
	end

	// Entry point of each operation's routine
	always_comb begin
		case (op)
			OP_ADD:   entry = P_ADD0;
			OP_READ:  entry = P_RD0;
			OP_WRITE: entry = P_WR0;
			default:  entry = P_RM0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else if (pc_q == P_IDLE) begin
			if (start) begin
				pc_q <= entry;
			end
		end else if (ucw.fin) begin
			pc_q <= P_IDLE;
		end else if (take) begin
			pc_q <= ucw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

@@ hw/rtl/packed_slot_map.sv @@
// Top level: packed slot map datapath with its three tables and the sequencer.
`timescale 1ns / 1ps
// Packed slot map: a 256-entry dense store addressed through stable handles.
// Request channel: drive req (op, handle, value) and raise start; the request
// is taken at the rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with rsp (status, handle_out,
// value_out, live_count); the result is taken at the edge ending that cycle.
// The receiver cannot stall, so results never back up.
// Steps per request in the microcode program:
//   add 2, full add 2, read 3, write 3, remove 4, bad handle 2 or 3.
// done follows in the cycle after the last step, and busy is already low in
// that cycle, so a new request may be taken alongside the strobe. Remove
// sets the worst case at 4 steps: it chains a table lookup, the reads of the
// last entry, and two rounds of writes through single-port-write RAMs.
// Reset clears the live and issued counts and done, and returns the sequencer to idle;
// table contents are left as they are and are only read once written.
module packed_slot_map
	import psm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	ctl_t   ctl;
	flags_t flags;

	logic [HANDLE_W-1:0]   h_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [ADDR_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     used_q;
	logic [SLOT_W-1:0]     issued_q;
	logic [1:0]            status_q;
	logic [HANDLE_W-1:0]   hout_q;
	logic [31:0]           vout_q;
	logic                  done_q;

	logic                  h2s_we;
	logic [ADDR_W-1:0]     h2s_waddr;
	logic [SLOT_W-1:0]     h2s_wdata;
	logic [ADDR_W-1:0]     h2s_raddr;
	logic [SLOT_W-1:0]     h2s_rdata;
	logic                  s2h_we;
	logic [ADDR_W-1:0]     s2h_waddr;
	logic [HANDLE_W-1:0]   s2h_wdata;
	logic [ADDR_W-1:0]     s2h_raddr;
	logic [HANDLE_W-1:0]   s2h_rdata;
	logic                  dat_we;
	logic [ADDR_W-1:0]     dat_waddr;
	logic [DATA_WIDTH-1:0] dat_wdata;
	logic [ADDR_W-1:0]     dat_raddr;
	logic [DATA_WIDTH-1:0] dat_rdata;

	logic                  accept;
	logic                  fresh;
	logic [ADDR_W-1:0]     new_h;
	logic [ADDR_W-1:0]     used_a;
	logic [ADDR_W-1:0]     last_a;

	assign accept = start && !busy;
	assign fresh  = (issued_q <= used_q);
	assign used_a = used_q[ADDR_W-1:0];
	assign last_a = ADDR_W'(used_q - 1'b1);
	assign new_h  = fresh ? used_a : s2h_rdata;

	assign flags.full  = (used_q == SLOT_W'(CAPACITY));
	assign flags.uniss = ({1'b0, h_q} >= issued_q);
	assign flags.dead  = (h2s_rdata >= used_q);

	psm_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.op    (req.op),
		.flags (flags),
		.busy  (busy),
		.ctl   (ctl)
	);

	psm_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_h2s (
		.clk  (clk),
		.we   (h2s_we),
		.waddr(h2s_waddr),
		.wdata(h2s_wdata),
		.raddr(h2s_raddr),
		.rdata(h2s_rdata)
	);

	psm_ram #(.WIDTH(HANDLE_W), .DEPTH(CAPACITY)) u_s2h (
		.clk  (clk),
		.we   (s2h_we),
		.waddr(s2h_waddr),
		.wdata(s2h_wdata),
		.raddr(s2h_raddr),
		.rdata(s2h_rdata)
	);

	psm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_dat (
		.clk  (clk),
		.we   (dat_we),
		.waddr(dat_waddr),
		.wdata(dat_wdata),
		.raddr(dat_raddr),
		.rdata(dat_rdata)
	);

	// Table ports per microcode action
	always_comb begin
		h2s_we    = 1'b0;
		h2s_waddr = '0;
		h2s_wdata = '0;
		h2s_raddr = h_q;
		s2h_we    = 1'b0;
		s2h_waddr = '0;
		s2h_wdata = '0;
		s2h_raddr = used_a;
		dat_we    = 1'b0;
		dat_waddr = '0;
		dat_wdata = '0;
		dat_raddr = h2s_rdata[ADDR_W-1:0];
		case (ctl.act)
			A_RD_FREE: s2h_raddr = used_a;
			A_ADD: begin
				h2s_we    = 1'b1;
				h2s_waddr = new_h;
				h2s_wdata = used_q;
				dat_we    = 1'b1;
				dat_waddr = used_a;
				dat_wdata = v_q;
				s2h_we    = fresh;
				s2h_waddr = used_a;
				s2h_wdata = used_a;
			end
			A_RD_H2S:  h2s_raddr = h_q;
			A_RD_DATA: dat_raddr = h2s_rdata[ADDR_W-1:0];
			A_WR: begin
				dat_we    = 1'b1;
				dat_waddr = slot_q;
				dat_wdata = v_q;
			end
			A_RM_RD: begin
				s2h_raddr = last_a;
				dat_raddr = last_a;
			end
			A_RM_MOVE: begin
				// move the last entry into the freed slot
				dat_we    = 1'b1;
				dat_waddr = slot_q;
				dat_wdata = dat_rdata;
				s2h_we    = 1'b1;
				s2h_waddr = slot_q;
				s2h_wdata = s2h_rdata;
				h2s_we    = 1'b1;
				h2s_waddr = s2h_rdata;
				h2s_wdata = {1'b0, slot_q};
			end
			A_RM_FREE: begin
				// push the handle onto the free stack and mark it dead
				s2h_we    = 1'b1;
				s2h_waddr = last_a;
				s2h_wdata = h_q;
				h2s_we    = 1'b1;
				h2s_waddr = h_q;
				h2s_wdata = DEAD_SLOT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q  <= req.handle;
			v_q  <= req.value[DATA_WIDTH-1:0];
		end
		if (ctl.act == A_SLOT || ctl.act == A_RM_RD) begin
			slot_q <= h2s_rdata[ADDR_W-1:0];
		end
		if (ctl.fin) begin
			case (ctl.act)
				A_ADD: begin
					status_q <= ST_OK;
					hout_q   <= new_h;
					vout_q   <= '0;
				end
				A_OUT: begin
					status_q <= ST_OK;
					hout_q   <= h_q;
					vout_q   <= 32'(dat_rdata);
				end
				A_FULL: begin
					status_q <= ST_FULL;
					hout_q   <= '0;
					vout_q   <= '0;
				end
				A_BAD: begin
					status_q <= ST_BAD;
					hout_q   <= h_q;
					vout_q   <= '0;
				end
				default: begin
					status_q <= ST_OK;
					hout_q   <= h_q;
					vout_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			issued_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			if (ctl.act == A_ADD) begin
				used_q <= used_q + 1'b1;
				if (fresh) begin
					issued_q <= used_q + 1'b1;
				end
			end else if (ctl.act == A_RM_FREE) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	assign done = done_q;
	assign rsp  = '{status: status_q, handle_out: hout_q, value_out: vout_q,
		live_count: 9'(used_q)};

`ifndef ASSERT_OFF
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SLOT_W'(CAPACITY))
		else $error("live count above capacity");
	a_used_issued: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= issued_q)
		else $error("more live entries than issued handles");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer still busy");
	a_full_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> (rsp.live_count == 9'(CAPACITY)))
		else $error("full status with free slots");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done || $past(ctl.fin))
		else $error("result strobe without a finishing step");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the packed slot map: directed rows, then random traffic.
`timescale 1ns / 1ps
module tb
	import psm_pkg::*;
();

	typedef struct packed {
		req_t stim;
		logic pinned;
		rsp_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 24;

	// Pinned rows carry a result fixed by hand; the rest use the predictor.
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{OP_READ,   8'd0,   32'd0},          1'b1, '{ST_BAD, 8'd0,   32'd0,          9'd0}},
		'{'{OP_REMOVE, 8'd255, 32'd0},          1'b1, '{ST_BAD, 8'd255, 32'd0,          9'd0}},
		'{'{OP_WRITE,  8'd7,   32'd1},          1'b1, '{ST_BAD, 8'd7,   32'd0,          9'd0}},
		'{'{OP_ADD,    8'd0,   32'd0},          1'b1, '{ST_OK,  8'd0,   32'd0,          9'd1}},
		'{'{OP_ADD,    8'd0,   32'hFFFF_FFFF},  1'b1, '{ST_OK,  8'd1,   32'd0,          9'd2}},
		'{'{OP_READ,   8'd1,   32'd0},          1'b1, '{ST_OK,  8'd1,   32'hFFFF_FFFF,  9'd2}},
		'{'{OP_READ,   8'd0,   32'd0},          1'b1, '{ST_OK,  8'd0,   32'd0,          9'd2}},
		'{'{OP_READ,   8'd2,   32'd0},          1'b1, '{ST_BAD, 8'd2,   32'd0,          9'd2}},
		'{'{OP_WRITE,  8'd0,   32'hA5A5_A5A5},  1'b1, '{ST_OK,  8'd0,   32'd0,          9'd2}},
		'{'{OP_READ,   8'd0,   32'd0},          1'b0, '0},
		'{'{OP_ADD,    8'd0,   32'h1234_5678},  1'b1, '{ST_OK,  8'd2,   32'd0,          9'd3}},
		'{'{OP_REMOVE, 8'd0,   32'd0},          1'b1, '{ST_OK,  8'd0,   32'd0,          9'd2}},
		'{'{OP_READ,   8'd0,   32'd0},          1'b1, '{ST_BAD, 8'd0,   32'd0,          9'd2}},
		'{'{OP_READ,   8'd2,   32'd0},          1'b0, '0},
		'{'{OP_REMOVE, 8'd0,   32'd0},          1'b1, '{ST_BAD, 8'd0,   32'd0,          9'd2}},
		'{'{OP_ADD,    8'd0,   32'h5A5A_5A5A},  1'b0, '0},
		'{'{OP_REMOVE, 8'd0,   32'd0},          1'b0, '0},
		'{'{OP_WRITE,  8'd0,   32'hFFFF_0000},  1'b0, '0},
		'{'{OP_REMOVE, 8'd1,   32'd0},          1'b0, '0},
		'{'{OP_REMOVE, 8'd2,   32'd0},          1'b0, '0},
		'{'{OP_READ,   8'd1,   32'd0},          1'b0, '0},
		'{'{OP_ADD,    8'd0,   32'h8000_0001},  1'b0, '0},
		'{'{OP_ADD,    8'd0,   32'h0000_0001},  1'b0, '0},
		'{'{OP_ADD,    8'd255, 32'h7FFF_FFFE},  1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	packed_slot_map dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// Mirror of the store: slot per handle, handle per slot, packed data.
	int        slot_of  [CAPACITY];
	int        owner_of [CAPACITY];
	bit [31:0] store    [CAPACITY];
	int        live_n;
	int        issued_n;

	rsp_t owed_results [$];
	int   mismatches;
	int   item_idx;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic rsp_t slot_map_apply(input req_t r);
		rsp_t o;
		int h, slot, last, last_h, nh;
		h = r.handle;
		o = '{status: ST_OK, handle_out: r.handle, value_out: '0, live_count: '0};
		if (r.op == OP_ADD) begin
			if (live_n >= CAPACITY) begin
				o.status = ST_FULL;
				o.handle_out = '0;
			end else begin
				slot = live_n;
				// Issue a fresh handle only when the free stack is empty.
				if (issued_n <= live_n) begin
					nh = live_n;
					owner_of[slot] = nh;
					issued_n = live_n + 1;
				end else begin
					nh = owner_of[slot];
				end
				slot_of[nh] = slot;
				store[slot] = r.value;
				live_n++;
				o.handle_out = 8'(nh);
			end
		end else if (!(h < issued_n && slot_of[h] < live_n)) begin
			o.status = ST_BAD;
		end else begin
			slot = slot_of[h];
			case (r.op)
				OP_READ: o.value_out = store[slot];
				OP_WRITE: store[slot] = r.value;
				default: begin
					// Move the last entry into the hole; push h onto the free stack.
					last = live_n - 1;
					last_h = owner_of[last];
					store[slot] = store[last];
					owner_of[slot] = last_h;
					owner_of[last] = h;
					slot_of[last_h] = slot;
					slot_of[h] = CAPACITY;
					live_n = last;
				end
			endcase
		end
		o.live_count = 9'(live_n);
		return o;
	endfunction

	function automatic req_t random_req(input int add_pct, input int rm_pct);
		req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < add_pct)
			r.op = OP_ADD;
		else if (roll < add_pct + rm_pct)
			r.op = OP_REMOVE;
		else
			r.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
		roll = $urandom_range(0, 99);
		if (live_n > 0 && roll < 70)
			r.handle = 8'(owner_of[$urandom_range(0, live_n - 1)]);
		else if (issued_n > live_n && roll < 82)
			r.handle = 8'(owner_of[$urandom_range(live_n, issued_n - 1)]);
		else
			r.handle = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: r.value = '0;
			1: r.value = '1;
			default: r.value = $urandom;
		endcase
		return r;
	endfunction

	task automatic send(input req_t r, input bit pinned, input rsp_t want);
		rsp_t guess;
		int gap;
		// Keep a long run of back-to-back transfers in the middle of the run.
		if ((item_idx < 200 || item_idx >= 300) && $urandom_range(0, 99) < 37) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		guess = slot_map_apply(r);
		owed_results.push_back(pinned ? want : guess);
		item_idx++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int count, input bit until_full, input int add_pct,
			input int rm_pct);
		int n;
		for (n = 0; until_full ? live_n < CAPACITY : n < count; n++)
			send(random_req(add_pct, rm_pct), 1'b0, '0);
		drain_results();
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with none expected: status %0d handle %0d value %0h live %0d",
					$time, rsp.status, rsp.handle_out, rsp.value_out, rsp.live_count);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("handle_out", 32'(want.handle_out), 32'(rsp.handle_out));
				check_field("value_out", want.value_out, rsp.value_out);
				check_field("live_count", 32'(want.live_count), 32'(rsp.live_count));
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		live_n = 0;
		issued_n = 0;
		mismatches = 0;
		item_idx = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++)
			send(DIRECTED[i].stim, DIRECTED[i].pinned, DIRECTED[i].want);
		drain_results();

		run_random(60, 1'b0, 40, 25);
		// Fill to capacity, then hammer the full store.
		run_random(0, 1'b1, 95, 2);
		run_random(15, 1'b0, 60, 0);
		run_random(120, 1'b0, 15, 70);
		run_random(60, 1'b0, 40, 30);

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ packed_slot_map.f @@
hw/rtl/psm_pkg.sv
hw/rtl/psm_ram.sv
hw/rtl/psm_seq.sv
hw/rtl/packed_slot_map.sv
tb/tb.sv
